// ----- design/pcan_pkg.sv -----
// ----------------------------------------------------------------------------
// pcan_pkg
// Shared types and constants of the path canonicaliser.
// ----------------------------------------------------------------------------
package pcan_pkg;

    localparam int PCAN_PATH_LEN = 128;

    localparam logic [7:0]  CH_NUL    = 8'h00;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_DOT    = 8'h2E;
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_DIR  = 2'd0,
        ACT_PATH = 2'd1,
        ACT_END  = 2'd2,
        ACT_READ = 2'd3
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] path_char;
        logic [6:0] read_index;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  result_char;
        logic [6:0]  path_length;
        logic [15:0] used_count;
    } t_out_word;

    // One byte write towards the output buffer.
    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } t_buf_wr;

endpackage

// ----- design/path_canonicalizer_top.sv -----
// ----------------------------------------------------------------------------
// path_canonicalizer_top
// Online Unix path canonicaliser with byte read-back.
// ----------------------------------------------------------------------------
// Usage: send current-directory bytes, then path bytes, as input words on
// i_in_valid / o_in_ready / i_in_word. An end word returns the length of the
// canonical path and the count of path bytes taken; a read word returns the
// byte at read_index, or zero past the end. Other words return nothing.
// Results leave on o_out_valid / i_out_ready / o_out_word, in order.
// A word sits in the input register and is folded as it leaves; its result
// is registered at that edge and offered from the output register. One word
// is taken every cycle unless a result waits on a stalled receiver;
// the fold is one pass of pointer and stack logic, with the output buffer
// in two banks so that a separator and a byte are stored together.
// When the receiver stalls, a result waits in the output register. Words
// that cause no result still pass; the next end or read word is taken and
// held in the input register, and o_in_ready then falls until the waiting
// result is taken. Reset empties both registers and sets the path to the
// root. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module path_canonicalizer_top import pcan_pkg::*; #(
    parameter int PATH_LEN = PCAN_PATH_LEN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int AW = $clog2(PATH_LEN);
    localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;

    logic          r_in_valid;
    t_in_word      r_in;
    logic          r_out_valid;
    t_out_word     r_out;
    t_out_word     n_out;

    logic          in_accept;
    logic          needs_out;
    logic          fire;
    t_buf_wr       wr_sep;
    t_buf_wr       wr_chr;
    logic [AW-1:0] wr_sep_addr;
    logic [AW-1:0] wr_chr_addr;
    logic [AW:0]   len;
    logic [15:0]   used;
    logic [7:0]    rd_data;

    assign needs_out  = (r_in.action == ACT_END) || (r_in.action == ACT_READ);
    assign fire       = r_in_valid && (!needs_out || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_accept  = i_in_valid && o_in_ready;

    pcan_fold #(.PATH_LEN(PATH_LEN)) u_fold (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_word        (r_in),
        .o_wr_sep      (wr_sep),
        .o_wr_sep_addr (wr_sep_addr),
        .o_wr_chr      (wr_chr),
        .o_wr_chr_addr (wr_chr_addr),
        .o_len         (len),
        .o_used        (used)
    );

    // The buffer is read as a word is accepted, so its data lines up with
    // the word in the input register.
    pcan_buf #(.PATH_LEN(PATH_LEN)) u_buf (
        .i_clk         (i_clk),
        .i_rd_en       (in_accept),
        .i_rd_index    (i_in_word.read_index),
        .i_wr_sep      (wr_sep),
        .i_wr_sep_addr (wr_sep_addr),
        .i_wr_chr      (wr_chr),
        .i_wr_chr_addr (wr_chr_addr),
        .o_rd_data     (rd_data)
    );

    always_comb begin
        n_out = '0;
        if (r_in.action == ACT_END) begin
            n_out.path_length = 7'(len);
            n_out.used_count  = used;
        end else if (CW'(r_in.read_index) < CW'(len)) begin
            n_out.result_char = rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire && needs_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
        if (fire && needs_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ----- design/pcan_fold.sv -----
// ----------------------------------------------------------------------------
// pcan_fold
// Folding state of the canonicaliser: write pointer, component tracking,
// counters and the stack of component restore positions.
// ----------------------------------------------------------------------------
module pcan_fold import pcan_pkg::*; #(
    parameter int PATH_LEN = PCAN_PATH_LEN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  t_in_word                      i_word,
    output t_buf_wr                       o_wr_sep,
    output logic [$clog2(PATH_LEN)-1:0]   o_wr_sep_addr,
    output t_buf_wr                       o_wr_chr,
    output logic [$clog2(PATH_LEN)-1:0]   o_wr_chr_addr,
    output logic [$clog2(PATH_LEN):0]     o_len,
    output logic [15:0]                   o_used
);

    localparam int AW    = $clog2(PATH_LEN);
    localparam int SLOTS = PATH_LEN / 2;
    localparam int SW    = $clog2(SLOTS);

    localparam logic [AW-1:0] TMAX       = AW'(PATH_LEN - 1);
    localparam logic [AW:0]   LAST       = (AW + 1)'(PATH_LEN - 1);
    localparam logic [SW:0]   SLOTS_FULL = (SW + 1)'(SLOTS);

    logic [AW:0]   r_wp,     n_wp;
    logic [SW:0]   r_depth,  n_depth;
    logic [1:0]    r_clen,   n_clen;
    logic          r_alld,   n_alld;
    logic [AW:0]   r_cstart, n_cstart;
    logic [AW-1:0] r_tcount, n_tcount;
    logic [15:0]   r_used,   n_used;
    logic          r_started, n_started;
    logic          r_ended,  n_ended;
    logic [AW:0]   r_top;
    logic          r_refill;
    logic [AW:0]   r_stk_q;
    logic [AW:0]   r_stack [SLOTS];

    logic          pre_sep;
    logic          fold_chr;
    logic          do_close;
    logic          push;
    logic          pop;
    logic [SW-1:0] push_addr;
    logic [AW:0]   push_data;
    logic [SW-1:0] stk_raddr;
    logic [7:0]    chr;

    always_comb begin
        n_wp          = r_wp;
        n_depth       = r_depth;
        n_clen        = r_clen;
        n_alld        = r_alld;
        n_cstart      = r_cstart;
        n_tcount      = r_tcount;
        n_used        = r_used;
        n_started     = r_started;
        n_ended       = r_ended;
        pre_sep       = 1'b0;
        fold_chr      = 1'b0;
        do_close      = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        push_addr     = '0;
        push_data     = '0;
        o_wr_sep      = '0;
        o_wr_sep_addr = '0;
        o_wr_chr      = '0;
        o_wr_chr_addr = '0;
        chr           = i_word.path_char;

        if (i_fire) begin
            unique case (i_word.action) inside
                ACT_DIR, ACT_PATH: begin
                    // The first byte after an end starts a fresh word.
                    if (r_ended) begin
                        n_wp      = (AW + 1)'(1);
                        n_depth   = '0;
                        n_clen    = '0;
                        n_alld    = 1'b1;
                        n_cstart  = '0;
                        n_tcount  = '0;
                        n_used    = '0;
                        n_started = 1'b0;
                        n_ended   = 1'b0;
                    end
                    if (chr != CH_NUL && chr != CH_SPACE) begin
                        if (i_word.action == ACT_DIR) begin
                            fold_chr = !n_started;
                        end else begin
                            fold_chr = 1'b1;
                            if (n_used != COUNT_MAX) begin
                                n_used = n_used + 1'b1;
                            end
                            if (!n_started) begin
                                n_started = 1'b1;
                                if (chr == CH_SLASH) begin
                                    // An absolute path discards the directory.
                                    n_wp     = (AW + 1)'(1);
                                    n_depth  = '0;
                                    n_clen   = '0;
                                    n_alld   = 1'b1;
                                    n_cstart = '0;
                                    n_tcount = '0;
                                end else begin
                                    pre_sep = 1'b1;
                                end
                            end
                        end
                    end
                end
                ACT_END: begin
                    do_close = 1'b1;
                    n_ended  = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // Implicit separator between the directory and a relative path.
        if (pre_sep && n_tcount < TMAX) begin
            n_tcount = n_tcount + 1'b1;
            do_close = 1'b1;
        end
        if (fold_chr && chr == CH_SLASH && n_tcount < TMAX) begin
            n_tcount = n_tcount + 1'b1;
            do_close = 1'b1;
        end

        if (do_close && n_clen != 2'd0) begin
            if (n_alld && n_clen != 2'd3) begin
                n_wp = n_cstart;
                if (n_clen == 2'd2 && n_depth != '0) begin
                    n_depth = n_depth - 1'b1;
                    n_wp    = r_top;
                    pop     = 1'b1;
                end
            end else if (n_depth < SLOTS_FULL) begin
                push      = 1'b1;
                push_addr = SW'(n_depth);
                push_data = n_cstart;
                n_depth   = n_depth + 1'b1;
            end
            n_clen = 2'd0;
            n_alld = 1'b1;
        end

        if (fold_chr && chr != CH_SLASH && n_tcount < TMAX) begin
            n_tcount = n_tcount + 1'b1;
            if (n_clen == 2'd0) begin
                n_cstart = n_wp;
                if (n_wp > (AW + 1)'(1)) begin
                    if (n_wp < LAST) begin
                        o_wr_sep.en   = 1'b1;
                        o_wr_sep.data = CH_SLASH;
                        o_wr_sep_addr = AW'(n_wp);
                    end
                    n_wp = n_wp + 1'b1;
                end
            end
            if (n_wp < LAST) begin
                o_wr_chr.en   = 1'b1;
                o_wr_chr.data = chr;
                o_wr_chr_addr = AW'(n_wp);
            end
            n_wp = n_wp + 1'b1;
            if (n_clen != 2'd3) begin
                n_clen = n_clen + 1'b1;
            end
            if (chr != CH_DOT) begin
                n_alld = 1'b0;
            end
        end
    end

    assign o_len     = (n_wp < LAST) ? n_wp : LAST;
    assign o_used    = n_used;
    assign stk_raddr = SW'(n_depth - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= (AW + 1)'(1);
            r_depth   <= '0;
            r_clen    <= '0;
            r_alld    <= 1'b1;
            r_cstart  <= '0;
            r_tcount  <= '0;
            r_used    <= '0;
            r_started <= 1'b0;
            r_ended   <= 1'b0;
            r_refill  <= 1'b0;
        end else begin
            r_wp      <= n_wp;
            r_depth   <= n_depth;
            r_clen    <= n_clen;
            r_alld    <= n_alld;
            r_cstart  <= n_cstart;
            r_tcount  <= n_tcount;
            r_used    <= n_used;
            r_started <= n_started;
            r_ended   <= n_ended;
            r_refill  <= pop;
        end
    end

    // The top of stack lives in a register. After a pop the new top is read
    // from the stack memory and loaded in the following cycle; a second pop always
    // needs at least two more dot bytes first.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[push_addr] <= push_data;
        end
        r_stk_q <= r_stack[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_top <= push_data;
        end else if (r_refill) begin
            r_top <= r_stk_q;
        end
    end

endmodule

// ----- design/pcan_buf.sv -----
// ----------------------------------------------------------------------------
// pcan_buf
// Output path buffer, split into even and odd banks so that a separator and
// a byte can be written together, with a registered read and write bypass.
// ----------------------------------------------------------------------------
module pcan_buf import pcan_pkg::*; #(
    parameter int PATH_LEN = PCAN_PATH_LEN
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [6:0]                    i_rd_index,
    input  t_buf_wr                       i_wr_sep,
    input  logic [$clog2(PATH_LEN)-1:0]   i_wr_sep_addr,
    input  t_buf_wr                       i_wr_chr,
    input  logic [$clog2(PATH_LEN)-1:0]   i_wr_chr_addr,
    output logic [7:0]                    o_rd_data
);

    localparam int AW   = $clog2(PATH_LEN);
    localparam int RW   = AW - 1;
    localparam int ROWS = 2 ** RW;

    logic [7:0]    r_bank_even [ROWS];
    logic [7:0]    r_bank_odd  [ROWS];

    logic          we_even;
    logic          we_odd;
    logic [RW-1:0] wrow_even;
    logic [RW-1:0] wrow_odd;
    logic [7:0]    wdata_even;
    logic [7:0]    wdata_odd;
    logic [AW-1:0] rd_addr;
    logic          hit;
    logic [7:0]    hit_data;

    logic [7:0]    r_q_even;
    logic [7:0]    r_q_odd;
    logic          r_sel;
    logic          r_zero;
    logic          r_hit;
    logic [7:0]    r_hit_data;

    // Two writes of one word always fall on neighbouring addresses.
    always_comb begin
        we_even    = 1'b0;
        we_odd     = 1'b0;
        wrow_even  = '0;
        wrow_odd   = '0;
        wdata_even = '0;
        wdata_odd  = '0;
        if (i_wr_sep.en && !i_wr_sep_addr[0]) begin
            we_even    = 1'b1;
            wrow_even  = i_wr_sep_addr[AW-1:1];
            wdata_even = i_wr_sep.data;
        end else if (i_wr_chr.en && !i_wr_chr_addr[0]) begin
            we_even    = 1'b1;
            wrow_even  = i_wr_chr_addr[AW-1:1];
            wdata_even = i_wr_chr.data;
        end
        if (i_wr_sep.en && i_wr_sep_addr[0]) begin
            we_odd    = 1'b1;
            wrow_odd  = i_wr_sep_addr[AW-1:1];
            wdata_odd = i_wr_sep.data;
        end else if (i_wr_chr.en && i_wr_chr_addr[0]) begin
            we_odd    = 1'b1;
            wrow_odd  = i_wr_chr_addr[AW-1:1];
            wdata_odd = i_wr_chr.data;
        end
    end

    assign rd_addr = AW'(i_rd_index);

    always_comb begin
        hit      = 1'b0;
        hit_data = '0;
        if (i_wr_chr.en && i_wr_chr_addr == rd_addr) begin
            hit      = 1'b1;
            hit_data = i_wr_chr.data;
        end else if (i_wr_sep.en && i_wr_sep_addr == rd_addr) begin
            hit      = 1'b1;
            hit_data = i_wr_sep.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_even) begin
            r_bank_even[wrow_even] <= wdata_even;
        end
        if (we_odd) begin
            r_bank_odd[wrow_odd] <= wdata_odd;
        end
        if (i_rd_en) begin
            r_q_even   <= r_bank_even[rd_addr[AW-1:1]];
            r_q_odd    <= r_bank_odd[rd_addr[AW-1:1]];
            r_sel      <= rd_addr[0];
            r_zero     <= (rd_addr == '0);
            r_hit      <= hit;
            r_hit_data <= hit_data;
        end
    end

    // Position zero always holds the root separator.
    assign o_rd_data = r_zero ? CH_SLASH :
                       r_hit  ? r_hit_data :
                       r_sel  ? r_q_odd : r_q_even;

endmodule

// ----- design/pcan_checker.sv -----
// ----------------------------------------------------------------------------
// pcan_checker
// Port-level checks of the path canonicaliser, bound to the top level.
// ----------------------------------------------------------------------------
module pcan_checker import pcan_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // A result word that is not taken stays put.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // Both registers come out of reset empty.
    a_reset_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

    // The input side only backs up behind a waiting result.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // A read result carries no length or count.
    a_read_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.result_char != 8'h00 |->
            o_out_word.path_length == 7'd0 && o_out_word.used_count == 16'd0)
        else $error("read result mixed with end fields");

endmodule

bind path_canonicalizer_top pcan_checker u_pcan_checker (.*);

// ----- test/pcan_result_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcan_result_check
// Watches both channels of the path canonicaliser, folds every accepted input
// word into its own copy of the path state, and compares each result word,
// field by field, with the oldest result still due.
// ----------------------------------------------------------------------------
module pcan_result_check import pcan_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int PATH_LEN    = PCAN_PATH_LEN;
    localparam int KEEP_MAX    = PATH_LEN - 1;
    localparam int STACK_SLOTS = PATH_LEN / 2;

    // Folded path and the bookkeeping around it.
    logic [7:0]  path_buf [PATH_LEN];
    int          restore_pos [STACK_SLOTS];
    int          wr_pos;
    int          stack_top;
    int          comp_len;
    int          comp_start;
    int          kept_bytes;
    bit          comp_dots;
    bit          path_open;
    bit          word_done;
    logic [15:0] path_bytes;

    t_out_word   due_results [$];
    int          fails = 0;

    task automatic clear_fold();
        path_buf[0] = CH_SLASH;
        wr_pos      = 1;
        stack_top   = 0;
        comp_len    = 0;
        comp_dots   = 1'b1;
        comp_start  = 0;
        kept_bytes  = 0;
    endtask

    task automatic clear_word();
        clear_fold();
        path_bytes = '0;
        path_open  = 1'b0;
        word_done  = 1'b0;
    endtask

    // Only the first PATH_LEN-1 bytes of the canonical path are stored.
    task automatic store_byte(input int pos, input logic [7:0] ch);
        if (pos < KEEP_MAX) begin
            path_buf[pos] = ch;
        end
    endtask

    task automatic close_component();
        if (comp_len == 0) begin
            return;
        end
        if (comp_dots && comp_len <= 2) begin
            wr_pos = comp_start;
            if (comp_len == 2 && stack_top > 0) begin
                stack_top--;
                wr_pos = restore_pos[stack_top];
            end
        end else if (stack_top < STACK_SLOTS) begin
            restore_pos[stack_top] = comp_start;
            stack_top++;
        end
        comp_len  = 0;
        comp_dots = 1'b1;
    endtask

    task automatic fold_byte(input logic [7:0] ch);
        if (kept_bytes >= KEEP_MAX) begin
            return;
        end
        kept_bytes++;
        if (ch == CH_SLASH) begin
            close_component();
            return;
        end
        if (comp_len == 0) begin
            comp_start = wr_pos;
            if (wr_pos > 1) begin
                store_byte(wr_pos, CH_SLASH);
                wr_pos++;
            end
        end
        store_byte(wr_pos, ch);
        wr_pos++;
        if (comp_len < 3) begin
            comp_len++;
        end
        if (ch != CH_DOT) begin
            comp_dots = 1'b0;
        end
    endtask

    function automatic int shown_len();
        return (wr_pos < KEEP_MAX) ? wr_pos : KEEP_MAX;
    endfunction

    // Folds one input word and works out the result word it causes, if any.
    task automatic apply_word(input t_in_word w, output bit gives, output t_out_word res);
        gives = 1'b0;
        res   = '0;
        case (w.action)
            ACT_DIR, ACT_PATH: begin
                if (word_done) begin
                    clear_word();
                end
                if (w.path_char != CH_NUL && w.path_char != CH_SPACE) begin
                    if (w.action == ACT_DIR) begin
                        if (!path_open) begin
                            fold_byte(w.path_char);
                        end
                    end else begin
                        if (path_bytes != COUNT_MAX) begin
                            path_bytes++;
                        end
                        if (!path_open) begin
                            path_open = 1'b1;
                            if (w.path_char == CH_SLASH) begin
                                clear_fold();
                            end else begin
                                fold_byte(CH_SLASH);
                            end
                        end
                        fold_byte(w.path_char);
                    end
                end
            end
            ACT_END: begin
                close_component();
                word_done       = 1'b1;
                gives           = 1'b1;
                res.path_length = 7'(shown_len());
                res.used_count  = path_bytes;
            end
            default: begin
                gives = 1'b1;
                if (int'(w.read_index) < shown_len()) begin
                    res.result_char = path_buf[w.read_index];
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        bit        gives;
        int        k;
        if (!i_rst_n) begin
            for (k = 0; k < PATH_LEN; k++) begin
                path_buf[k] = '0;
            end
            for (k = 0; k < STACK_SLOTS; k++) begin
                restore_pos[k] = 0;
            end
            clear_word();
            due_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                apply_word(i_in_word, gives, want);
                if (gives) begin
                    due_results.push_back(want);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result word with none due: %h", $time, i_out_word);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    if (i_out_word.result_char !== want.result_char) begin
                        $display("%0t: result_char expected %h actual %h",
                                 $time, want.result_char, i_out_word.result_char);
                        fails++;
                    end
                    if (i_out_word.path_length !== want.path_length) begin
                        $display("%0t: path_length expected %0d actual %0d",
                                 $time, want.path_length, i_out_word.path_length);
                        fails++;
                    end
                    if (i_out_word.used_count !== want.used_count) begin
                        $display("%0t: used_count expected %0d actual %0d",
                                 $time, want.used_count, i_out_word.used_count);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives current-directory and path words into the path canonicaliser, with
// directed corner cases first and then randomly built words, under changing
// idle patterns on both sides, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;
    import pcan_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RANDOM_WORDS    = 1850;
    localparam int TAIL_CYCLES     = 20;
    localparam int LONG_PATH_BYTES = 160;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int in_idle_pct  = 37;
    int out_idle_pct = 85;
    int words_sent   = 0;

    path_canonicalizer_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    pcan_result_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input t_action act, input logic [7:0] ch, input logic [6:0] idx);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        in_word.action     <= act;
        in_word.path_char  <= ch;
        in_word.read_index <= idx;
        do @(posedge clk); while (!in_ready);
        if (act == ACT_END || act == ACT_READ || (ch != CH_NUL && ch != CH_SPACE)) begin
            words_sent++;
        end
    endtask

    // Holds the sender off until every result due has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] name_char();
        case ($urandom_range(5))
            0:       return 8'($urandom_range(1, 255));
            1:       return CH_DOT;
            default: return CH_LOWER_A + 8'($urandom_range(25));
        endcase
    endfunction

    function automatic logic [6:0] read_pos();
        return ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(24));
    endfunction

    // Sends components with separators; dot components are common so that the
    // pop logic is exercised, and a little noise is mixed in.
    task automatic send_segment(input t_action act, input int n_comp, input bit lead_slash);
        int k;
        int n;
        if (lead_slash) begin
            send_word(act, CH_SLASH, read_pos());
        end
        for (k = 0; k < n_comp; k++) begin
            if (k > 0) begin
                n = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
                repeat (n) send_word(act, CH_SLASH, read_pos());
            end
            case ($urandom_range(7))
                0: send_word(act, CH_DOT, read_pos());
                1, 2: repeat (2) send_word(act, CH_DOT, read_pos());
                3: repeat (3) send_word(act, CH_DOT, read_pos());
                default: repeat ($urandom_range(1, 6)) send_word(act, name_char(), read_pos());
            endcase
            case ($urandom_range(15))
                0: send_word(act, CH_NUL, read_pos());
                1: send_word(act, CH_SPACE, read_pos());
                2: send_word(ACT_READ, name_char(), read_pos());
                3: send_word(ACT_DIR, name_char(), read_pos());
                default: ;
            endcase
        end
        if ($urandom_range(3) == 0) begin
            send_word(act, CH_SLASH, read_pos());
        end
    endtask

    task automatic random_word();
        bit big;
        big = ($urandom_range(9) == 0);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                send_word(t_action'(2'($urandom_range(3))), 8'($urandom_range(255)),
                          7'($urandom_range(127)));
            end
            return;
        end
        send_segment(ACT_DIR, big ? $urandom_range(8, 30) : $urandom_range(0, 4),
                     $urandom_range(3) != 0);
        send_segment(ACT_PATH, big ? $urandom_range(10, 40) : $urandom_range(0, 5),
                     $urandom_range(2) == 0);
        send_word(ACT_END, 8'($urandom_range(255)), read_pos());
        repeat ($urandom_range(0, 4)) send_word(ACT_READ, name_char(), read_pos());
        if ($urandom_range(7) == 0) begin
            send_word(ACT_END, name_char(), read_pos());
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset state, dropped bytes, dot handling, root, repeats.
        send_word(ACT_END, CH_NUL, 7'd0);
        send_word(ACT_READ, CH_NUL, 7'd0);
        send_word(ACT_READ, CH_NUL, 7'd127);
        send_word(ACT_DIR, 8'h78, 7'd0);
        send_word(ACT_DIR, CH_NUL, 7'd0);
        send_word(ACT_PATH, CH_SPACE, 7'd0);
        send_word(ACT_PATH, CH_DOT, 7'd0);
        send_word(ACT_PATH, CH_DOT, 7'd0);
        send_word(ACT_PATH, CH_SLASH, 7'd0);
        send_word(ACT_DIR, 8'h71, 7'd0);
        send_word(ACT_PATH, 8'hFF, 7'd0);
        send_word(ACT_READ, CH_NUL, 7'd1);
        send_word(ACT_PATH, CH_SLASH, 7'd0);
        send_word(ACT_PATH, CH_DOT, 7'd0);
        send_word(ACT_PATH, CH_SLASH, 7'd0);
        repeat (3) send_word(ACT_PATH, CH_DOT, 7'd0);
        send_word(ACT_END, CH_NUL, 7'd0);
        send_word(ACT_END, CH_NUL, 7'd0);
        send_word(ACT_READ, CH_NUL, 7'd2);
        send_word(ACT_PATH, CH_SLASH, 7'd0);
        send_word(ACT_PATH, CH_DOT, 7'd0);
        send_word(ACT_PATH, CH_DOT, 7'd0);
        send_word(ACT_PATH, CH_SLASH, 7'd0);
        send_word(ACT_PATH, 8'h80, 7'd0);
        send_word(ACT_END, CH_NUL, 7'd0);
        send_word(ACT_READ, CH_NUL, 7'h55);
        send_word(ACT_DIR, 8'h01, 7'd0);
        send_word(ACT_END, CH_NUL, 7'h2A);
        drain_results();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS / 3) begin
            random_word();
        end
        drain_results();

        in_idle_pct  = 85;
        out_idle_pct = 37;
        while (words_sent < 2 * RANDOM_WORDS / 3) begin
            random_word();
        end
        drain_results();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        while (words_sent < RANDOM_WORDS) begin
            random_word();
        end

        // One long path word that runs well past the length bound.
        send_word(ACT_PATH, CH_SLASH, 7'd0);
        repeat (LONG_PATH_BYTES) begin
            send_word(ACT_PATH, ($urandom_range(4) == 0) ? CH_SLASH : name_char(), read_pos());
        end
        send_word(ACT_END, CH_NUL, 7'd0);
        repeat (4) send_word(ACT_READ, CH_NUL, read_pos());

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
